// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IBA_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define IBA_ASSERT_NR(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define IBA_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define IBA_ASSERT_NR(lbl, clk_s, prop, msg)
`endif
`endif

// ===== hw/rtl/iba_pkg.sv =====
// Types and codes for the indexed block allocator.
package iba_pkg;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CHECK = 4'b0100,
		S_SCAN  = 4'b1000
	} iba_state_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_USED = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] block_number;
		logic [1:0] index_block;
		logic [4:0] slot;
		logic       last;
	} iba_result_t;

endpackage

// ===== hw/rtl/indexed_block_allocator_core.sv =====
// Indexed block allocator: used-block map in one synchronous RAM, scanned one block per cycle
// while the result output is not stalled. After reset a clearing pass writes every map entry
// free; no request is taken then. A request is taken only in idle; its start block is read at
// acceptance and its first result is registered from the check state. Each scan step checks one
// block (one RAM read port); the next request is taken only once the block is back in idle.
// A rejection gives one result from the check state; a start past the disk end at acceptance.
`include "assert_macros.svh"

module indexed_block_allocator_core
	import iba_pkg::*;
#(
	parameter int NUM_BLOCKS        = 256,
	parameter int ENTRIES_PER_INDEX = 20,
	parameter int MAX_LENGTH        = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] start_block,
	input  logic [6:0] file_length,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [7:0] block_number,
	output logic [1:0] index_block,
	output logic [4:0] slot,
	output logic       last
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);

	iba_state_t state_q, state_d;

	logic          used_mem [NUM_BLOCKS];
	logic          map_rd_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;

	logic [AW-1:0] clr_q;
	logic [CW-1:0] chk_q, chk_d;
	logic [6:0]    len_q, len_d;
	logic [6:0]    pos_q, pos_d;
	logic [7:0]    slot_q, slot_d;
	logic [6:0]    idx_q, idx_d;
	logic [7:0]    start_q;

	logic          res_valid_q;
	iba_result_t   res_q, res_d;
	logic          emit;
	logic          out_free;
	logic [6:0]    len_min1;
	logic [CW-1:0] chk_next;
	logic          next_in_range;
	logic          pos_is_last;

	assign out_free = !res_valid_q || !res_stall;
	assign req_stall = !((state_q == S_IDLE) && out_free);

	assign len_min1 = (file_length == 7'd0) ? 7'd1 : file_length;
	assign chk_next = chk_q + CW'(1);
	assign next_in_range = (32'(chk_next) < 32'(NUM_BLOCKS));
	assign pos_is_last = ((pos_q + 7'd1) == len_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			used_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			map_rd_q <= used_mem[rd_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		chk_d   = chk_q;
		len_d   = len_q;
		pos_d   = pos_q;
		slot_d  = slot_q;
		idx_d   = idx_q;
		rd_en   = 1'b0;
		rd_addr = AW'(chk_next);
		wr_en   = 1'b0;
		wr_addr = AW'(chk_q);
		wr_data = 1'b1;
		emit    = 1'b0;
		res_d   = '{status: STAT_OK, block_number: 8'(chk_q), index_block: 2'(idx_q),
			slot: 5'(slot_q), last: pos_is_last};
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = 1'b0;
				if (clr_q == AW'(NUM_BLOCKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid && out_free) begin
					len_d  = (32'(len_min1) > 32'(MAX_LENGTH)) ? 7'(MAX_LENGTH) : len_min1;
					pos_d  = 7'd0;
					slot_d = 8'd0;
					idx_d  = 7'd0;
					chk_d  = CW'(start_block);
					if (32'(start_block) >= 32'(NUM_BLOCKS)) begin
						emit  = 1'b1;
						res_d = '{status: STAT_FULL, block_number: 8'd0, index_block: 2'd0,
							slot: 5'd0, last: 1'b1};
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(start_block);
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK, S_SCAN: begin
				if (state_q == S_SCAN && !(32'(chk_q) < 32'(NUM_BLOCKS))) begin
					// scan ran off the disk end
					if (out_free) begin
						emit    = 1'b1;
						res_d   = '{status: STAT_FULL, block_number: 8'd0, index_block: 2'd0,
							slot: 5'd0, last: 1'b1};
						state_d = S_IDLE;
					end
				end else if (map_rd_q) begin
					if (state_q == S_CHECK) begin
						if (out_free) begin
							emit    = 1'b1;
							res_d   = '{status: STAT_USED, block_number: start_q,
								index_block: 2'd0, slot: 5'd0, last: 1'b1};
							state_d = S_IDLE;
						end
					end else begin
						// skip a used block, look at the next one
						rd_en = next_in_range;
						chk_d = chk_next;
					end
				end else if (out_free) begin
					wr_en = 1'b1;
					emit  = 1'b1;
					if (pos_is_last) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = next_in_range;
						chk_d   = chk_next;
						pos_d   = pos_q + 7'd1;
						state_d = S_SCAN;
						if (slot_q == 8'(ENTRIES_PER_INDEX - 1)) begin
							slot_d = 8'd0;
							idx_d  = idx_q + 7'd1;
						end else begin
							slot_d = slot_q + 8'd1;
						end
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_q  <= chk_d;
		len_q  <= len_d;
		pos_q  <= pos_d;
		slot_q <= slot_d;
		idx_q  <= idx_d;
		if (state_q == S_IDLE) begin
			start_q <= start_block;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = res_q.status;
	assign block_number = res_q.block_number;
	assign index_block  = res_q.index_block;
	assign slot         = res_q.slot;
	assign last         = res_q.last;

	`IBA_ASSERT(a_mark_only_free, clk, arst_n, (wr_en && wr_data) |-> !map_rd_q, "marking a used block")
	`IBA_ASSERT(a_pos_in_len, clk, arst_n, (state_q == S_SCAN) |-> (pos_q < len_q), "position past length")
	`IBA_ASSERT(a_err_is_last, clk, arst_n, (res_valid && status != STAT_OK) |-> last, "error result not last")
	`IBA_ASSERT(a_no_emit_on_stall, clk, arst_n, (res_valid_q && res_stall) |-> !emit, "result overwritten while stalled")

endmodule

// ===== tb/indexed_block_allocator_core_test.sv =====
// Self-checking testbench for the indexed block allocator: directed and random file requests.
module indexed_block_allocator_core_test
	import iba_pkg::*;
();

	localparam int DISK_BLOCKS     = 256;
	localparam int INDEX_ENTRIES   = 20;
	localparam int LENGTH_CAP      = 64;
	localparam int RANDOM_REQUESTS = 470;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 5000;

	// Tracks the used-block map and the grants each request should produce.
	class allocation_tracker;
		bit          disk_used [DISK_BLOCKS];
		iba_result_t pending_grants [$];
		int unsigned error_count = 0;

		function bit block_free(int unsigned b);
			return !disk_used[b];
		endfunction

		function int unsigned outstanding();
			return pending_grants.size();
		endfunction

		function void expect_grant(logic [1:0] st, int unsigned blk, int unsigned position,
				bit is_last);
			iba_result_t r;
			r.status       = st;
			r.block_number = blk[7:0];
			r.index_block  = 2'(position / INDEX_ENTRIES);
			r.slot         = 5'(position % INDEX_ENTRIES);
			r.last         = is_last;
			pending_grants.push_back(r);
		endfunction

		function void take_request(logic [7:0] sb, logic [6:0] fl);
			int unsigned want;
			int unsigned cursor;
			int unsigned position;
			want = fl;
			if (want == 0) want = 1;
			if (want > LENGTH_CAP) want = LENGTH_CAP;
			if (sb >= DISK_BLOCKS) begin
				expect_grant(STAT_FULL, 0, 0, 1'b1);
				return;
			end
			if (disk_used[sb]) begin
				// rejection carries the requested start block, index fields zero
				expect_grant(STAT_USED, sb, 0, 1'b1);
				return;
			end
			disk_used[sb] = 1'b1;
			cursor = sb;
			expect_grant(STAT_OK, cursor, 0, want == 1);
			for (position = 1; position < want; position++) begin
				cursor++;
				while (cursor < DISK_BLOCKS && disk_used[cursor]) cursor++;
				if (cursor >= DISK_BLOCKS) begin
					// ran off the disk end; blocks granted so far stay used
					expect_grant(STAT_FULL, 0, 0, 1'b1);
					return;
				end
				disk_used[cursor] = 1'b1;
				expect_grant(STAT_OK, cursor, position, position + 1 == want);
			end
		endfunction

		function void check_grant(iba_result_t got);
			iba_result_t want;
			if (pending_grants.size() == 0) begin
				$error("unexpected result: status %0d block %0d", got.status, got.block_number);
				error_count++;
				return;
			end
			want = pending_grants.pop_front();
			if (got.status != want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				error_count++;
			end
			if (got.block_number != want.block_number) begin
				$error("block_number: expected %0d, got %0d", want.block_number,
					got.block_number);
				error_count++;
			end
			if (got.index_block != want.index_block) begin
				$error("index_block: expected %0d, got %0d", want.index_block, got.index_block);
				error_count++;
			end
			if (got.slot != want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, got.slot);
				error_count++;
			end
			if (got.last != want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				error_count++;
			end
		endfunction
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       req_valid    = 1'b0;
	logic       req_stall;
	logic [7:0] start_block  = 8'd0;
	logic [6:0] file_length  = 7'd0;
	logic       res_valid;
	logic       res_stall    = 1'b0;
	logic [1:0] status;
	logic [7:0] block_number;
	logic [1:0] index_block;
	logic [4:0] slot;
	logic       last;

	allocation_tracker tracker;
	bit                hold_off_due = 1'b0;
	bit                drain        = 1'b0;
	int unsigned       idle_cycles  = 0;

	indexed_block_allocator_core #(
		.NUM_BLOCKS(DISK_BLOCKS),
		.ENTRIES_PER_INDEX(INDEX_ENTRIES),
		.MAX_LENGTH(LENGTH_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.start_block(start_block),
		.file_length(file_length),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.block_number(block_number),
		.index_block(index_block),
		.slot(slot),
		.last(last)
	);

	always #5 clk = ~clk;

	task automatic offer_request(input logic [7:0] sb, input logic [6:0] fl);
		start_block <= sb;
		file_length <= fl;
		req_valid   <= 1'b1;
		do @(posedge clk); while (req_stall);
		tracker.take_request(sb, fl);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_grant({status, block_number, index_block, slot, last});
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[indexed_block_allocator_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		int unsigned k;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (drain) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else if (hold_off_due) begin
				// long hold-off so the block backs up and stalls requests
				hold_off_due = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 40);
				for (k = 0; k < span; k++) begin
					case (mode)
						0: res_stall <= 1'b0;
						1: res_stall <= 1'($urandom_range(0, 1));
						2: res_stall <= ($urandom_range(0, 7) == 0);
						default: res_stall <= (k < span / 3);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned k;
		int unsigned b;
		int unsigned pick;
		int unsigned burst_left;
		logic [7:0] sb;
		logic [6:0] fl;
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		offer_request(8'd0, 7'd0);      // zero length acts as one
		offer_request(8'd0, 7'd3);      // start already used
		offer_request(8'd1, 7'd127);    // cut to the cap, all four index blocks
		offer_request(8'd10, 7'd2);
		pause_sender(3);
		offer_request(8'd66, 7'd1);
		offer_request(8'd65, 7'd3);     // scan hops over 66
		offer_request(8'd250, 7'd3);
		offer_request(8'd249, 7'd20);   // runs off the disk end
		offer_request(8'd255, 7'd1);
		pause_sender(2);
		offer_request(8'd128, 7'd20);   // exactly one full index block
		offer_request(8'd148, 7'd21);   // spills into the second index block
		offer_request(8'd248, 7'd64);   // nothing free above: full right after start
		offer_request(8'd127, 7'd2);    // long scan over a used run

		// let everything drain before the random part
		pause_sender(1);
		while (tracker.outstanding() != 0) @(posedge clk);

		hold_off_due = 1'b1;
		burst_left = 0;
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
			end
			burst_left--;
			if ($urandom_range(0, 9) < 7) begin
				// mostly aim at a free block so requests get past the used check
				b = $urandom_range(0, DISK_BLOCKS - 1);
				for (k = 0; k < DISK_BLOCKS && !tracker.block_free(b); k++)
					b = (b + 1) % DISK_BLOCKS;
				sb = b[7:0];
			end else begin
				sb = 8'($urandom_range(0, 255));
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) fl = 7'($urandom_range(1, 3));
			else if (pick < 85) fl = 7'($urandom_range(4, 16));
			else if (pick < 95) fl = 7'($urandom_range(17, 64));
			else fl = 7'($urandom_range(0, 127));
			offer_request(sb, fl);
		end

		pause_sender(1);
		drain = 1'b1;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (tracker.error_count == 0)
			$display("[indexed_block_allocator_core] OK");
		else
			$display("[indexed_block_allocator_core] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/iba_pkg.sv
hw/rtl/indexed_block_allocator_core.sv
tb/indexed_block_allocator_core_test.sv
